/* rtl/core/iiea_pkg.sv */
// Shared types and constants for the indexed insert/erase array.
// No dependencies; imported by iiea_cell and indexed_insert_erase_array.
package iiea_pkg;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_ERASE  = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    localparam int unsigned POS_BITS = 6;
    localparam int unsigned CMP_BITS = 9;
    localparam logic [POS_BITS-1:0] CAP_RESET = 6'd32;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                shift_up;
        logic                shift_down;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] cnt;
    } t_cell_cmd;

endpackage

/* rtl/core/indexed_insert_erase_array.sv */
// Top level of the indexed insert/erase array: a row of iiea_cell storage
// cells plus request decode and the result register. Depends on iiea_pkg.
//
// Usage:
//   Request channel: i_in_valid / o_in_stall carry func, position, value.
//   Result channel: o_out_valid / i_out_stall carry read_value, position_out,
//   size_now and status. Every request gives exactly one result.
//   The result is registered at the edge that takes the request. Throughput
//   is one request per cycle while the receiver does not stall; all cells
//   shift to their neighbors in parallel at that same edge.
//   When the receiver stalls, the result register holds its contents and
//   o_in_stall rises so no further request enters until it drains.
//   Capacity is written through i_cfg_we / i_cfg_wdata while idle; values
//   above DEPTH act as DEPTH.
//   Reset (synchronous, active low) empties the array, clears the result
//   valid flag and sets the capacity to 32. Stored words are not cleared;
//   only written entries are ever read.
module indexed_insert_erase_array #(
    parameter int DEPTH     = 32,
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_read_value,
    output logic [5:0]         o_position_out,
    output logic [5:0]         o_size_now,
    output logic [1:0]         o_status
);
    import iiea_pkg::*;

    localparam logic [CMP_BITS-1:0] DEPTH_C = CMP_BITS'(DEPTH);
    localparam int RD_CELLS = (DEPTH > 64) ? 64 : DEPTH;

    logic [POS_BITS-1:0] r_cap;
    logic [POS_BITS-1:0] r_count;
    logic [POS_BITS-1:0] n_count;
    logic                r_out_valid;
    logic [31:0]         r_rd;
    logic [31:0]         n_rd;
    logic [POS_BITS-1:0] r_pos_out;
    logic [POS_BITS-1:0] n_pos_out;
    t_status             r_status;
    t_status             n_status;

    logic                 w_accept;
    t_func                w_func;
    logic [CMP_BITS-1:0]  w_cnt_c;
    logic [CMP_BITS-1:0]  w_pos_c;
    logic                 w_full;
    logic                 w_range;
    logic [POS_BITS-1:0]  w_ins_pos;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_BITS-1:0] w_rd_word;
    logic [31:0]          w_rd32;
    t_cell_cmd            w_cmd;
    logic [WORD_BITS-1:0] w_cell [DEPTH];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_func     = t_func'(i_func);
    assign w_cnt_c    = CMP_BITS'(r_count);
    assign w_pos_c    = CMP_BITS'(i_position);
    assign w_full     = (w_cnt_c >= CMP_BITS'(r_cap)) || (w_cnt_c >= DEPTH_C);
    assign w_range    = (w_pos_c >= w_cnt_c) || (w_pos_c >= DEPTH_C);
    assign w_ins_pos  = (w_func == FUNC_APPEND || i_position > r_count) ?
                        r_count : i_position;

    generate
        if (WORD_BITS <= 32) begin : g_wnarrow
            assign w_wdata = i_value[WORD_BITS-1:0];
            assign w_rd32  = 32'(w_rd_word);
        end else begin : g_wwide
            assign w_wdata = WORD_BITS'(unsigned'(i_value));
            assign w_rd32  = w_rd_word[31:0];
        end
    endgenerate

    always_comb begin
        w_rd_word = '0;
        for (int k = 0; k < RD_CELLS; k++) begin
            if (i_position == POS_BITS'(k)) begin
                w_rd_word = w_rd_word | w_cell[k];
            end
        end
    end

    always_comb begin
        w_cmd.shift_up   = 1'b0;
        w_cmd.shift_down = 1'b0;
        w_cmd.pos        = w_ins_pos;
        w_cmd.cnt        = r_count;
        n_count          = r_count;
        n_rd             = '0;
        n_pos_out        = '0;
        n_status         = STAT_OK;
        unique case (w_func)
            FUNC_APPEND, FUNC_INSERT: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    w_cmd.shift_up = w_accept;
                    n_count        = r_count + POS_BITS'(1);
                    n_pos_out      = w_ins_pos;
                end
            end
            FUNC_ERASE: begin
                w_cmd.pos = i_position;
                if (w_range) begin
                    n_status = STAT_RANGE;
                end else begin
                    w_cmd.shift_down = w_accept;
                    n_count          = r_count - POS_BITS'(1);
                    n_pos_out        = i_position;
                end
            end
            FUNC_READ: begin
                w_cmd.pos = i_position;
                if (w_range) begin
                    n_status = STAT_RANGE;
                end else begin
                    n_rd      = w_rd32;
                    n_pos_out = i_position;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_BITS-1:0] w_left;
            logic [WORD_BITS-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell[g+1];
            end
            iiea_cell #(
                .IDX       (g),
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_wdata (w_wdata),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd      <= n_rd;
            r_pos_out <= n_pos_out;
            r_status  <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = signed'(r_rd);
    assign o_position_out = r_pos_out;
    assign o_size_now     = r_count;
    assign o_status       = r_status;

endmodule

/* rtl/core/iiea_cell.sv */
// One storage cell of the array row: holds a word, loads from its lower
// or upper neighbor or from the broadcast word. Depends on iiea_pkg.
module iiea_cell #(
    parameter int IDX       = 0,
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  iiea_pkg::t_cell_cmd   i_cmd,
    input  logic [WORD_BITS-1:0]  i_wdata,
    input  logic [WORD_BITS-1:0]  i_left,
    input  logic [WORD_BITS-1:0]  i_right,
    output logic [WORD_BITS-1:0]  o_data
);
    import iiea_pkg::*;

    localparam logic [CMP_BITS-1:0] IDX_C = CMP_BITS'(IDX);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic [CMP_BITS-1:0]  w_pos;
    logic [CMP_BITS-1:0]  w_cnt;

    assign w_pos = CMP_BITS'(i_cmd.pos);
    assign w_cnt = CMP_BITS'(i_cmd.cnt);

    always_comb begin
        n_data = r_data;
        if (i_cmd.shift_up) begin
            if (IDX_C == w_pos) begin
                n_data = i_wdata;
            end else if (IDX_C > w_pos && IDX_C <= w_cnt) begin
                n_data = i_left;
            end
        end else if (i_cmd.shift_down) begin
            if (IDX_C >= w_pos && (IDX_C + CMP_BITS'(1)) < w_cnt) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* verif/tb_indexed_insert_erase_array.sv */
// Self-checking testbench for indexed_insert_erase_array: directed table plus
// random append/insert/erase/read traffic under several capacity settings.
// Depends on iiea_pkg and the RTL top level; predicts each non-chk result.
module tb_indexed_insert_erase_array;
    timeunit 1ns;
    timeprecision 1ps;

    import iiea_pkg::*;

    localparam int DEPTH          = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 60;
    localparam int NUM_PHASES     = 11;

    typedef struct packed {
        logic signed [31:0] rd;
        logic [5:0]         pos;
        logic [5:0]         size;
        t_status            st;
    } t_result;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [5:0]  cap;
        t_func       f;
        logic [5:0]  p;
        logic [31:0] v;
        bit          chk;
        t_result     exp;
    } t_stim_row;

    localparam int DIR_ROWS = 27;

    // chk rows carry a hand-written expectation; the rest use the predictor
    t_stim_row dir_tab [0:DIR_ROWS-1] = '{
        '{ROW_REQ, 6'd0,  FUNC_READ,   6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, 6'd0, STAT_RANGE}},
        '{ROW_REQ, 6'd0,  FUNC_ERASE,  6'd0,  32'h0,        1'b1, '{32'h0, 6'd0, 6'd0, STAT_RANGE}},
        '{ROW_REQ, 6'd0,  FUNC_APPEND, 6'd0,  32'h7fffffff, 1'b1, '{32'h0, 6'd0, 6'd1, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_APPEND, 6'd63, 32'h80000000, 1'b1, '{32'h0, 6'd1, 6'd2, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_INSERT, 6'd0,  32'hffffffff, 1'b1, '{32'h0, 6'd0, 6'd3, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_INSERT, 6'd63, 32'h0,        1'b1, '{32'h0, 6'd3, 6'd4, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_INSERT, 6'd2,  32'h12345678, 1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_READ,   6'd0,  32'h0,        1'b1, '{32'hffffffff, 6'd0, 6'd5, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_READ,   6'd4,  32'hdeadbeef, 1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_READ,   6'd5,  32'h0,        1'b1, '{32'h0, 6'd0, 6'd5, STAT_RANGE}},
        '{ROW_REQ, 6'd0,  FUNC_ERASE,  6'd4,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_ERASE,  6'd0,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_READ,   6'd63, 32'h0,        1'b1, '{32'h0, 6'd0, 6'd3, STAT_RANGE}},
        '{ROW_REQ, 6'd0,  FUNC_READ,   6'd2,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_CFG, 6'd3,  FUNC_READ,   6'd0,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_APPEND, 6'd0,  32'h1,        1'b1, '{32'h0, 6'd0, 6'd3, STAT_FULL}},
        '{ROW_CFG, 6'd2,  FUNC_READ,   6'd0,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_INSERT, 6'd0,  32'h2,        1'b1, '{32'h0, 6'd0, 6'd3, STAT_FULL}},
        '{ROW_REQ, 6'd0,  FUNC_ERASE,  6'd1,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_APPEND, 6'd0,  32'h3,        1'b1, '{32'h0, 6'd0, 6'd2, STAT_FULL}},
        '{ROW_CFG, 6'd0,  FUNC_READ,   6'd0,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_INSERT, 6'd1,  32'h4,        1'b1, '{32'h0, 6'd0, 6'd2, STAT_FULL}},
        '{ROW_REQ, 6'd0,  FUNC_ERASE,  6'd0,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_READ,   6'd0,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_CFG, 6'd63, FUNC_READ,   6'd0,  32'h0,        1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_APPEND, 6'd0,  32'h55aa55aa, 1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}},
        '{ROW_REQ, 6'd0,  FUNC_INSERT, 6'd1,  32'haa55aa55, 1'b0, '{32'h0, 6'd0, 6'd0, STAT_OK}}
    };

    int phase_cap [0:NUM_PHASES-1] = '{63, 32, 1, 0, 20, 32, 5, 40, 2, 31, 63};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [5:0]         i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_func;
    logic [5:0]         i_position;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_read_value;
    logic [5:0]         o_position_out;
    logic [5:0]         o_size_now;
    logic [1:0]         o_status;

    indexed_insert_erase_array #(
        .DEPTH     (DEPTH),
        .WORD_BITS (32)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_value   (o_read_value),
        .o_position_out (o_position_out),
        .o_size_now     (o_size_now),
        .o_status       (o_status)
    );

    // shadow copy of the array
    logic [31:0] model_words [0:DEPTH-1];
    int          model_count = 0;
    logic [5:0]  model_cap   = CAP_RESET;

    t_result pending_results [$];
    bit      cur_chk;
    t_result cur_exp;
    int      idle_cycles = 0;
    int      n_req = 0;
    int      n_res = 0;
    int      n_cfg = 0;
    int      n_err = 0;
    int      n_stat [0:2] = '{0, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result apply_request(t_func f, logic [5:0] p, logic [31:0] v);
        t_result r;
        int      eff;
        int      slot;
        r   = '{32'h0, 6'd0, 6'd0, STAT_OK};
        eff = (model_cap > DEPTH) ? DEPTH : int'(model_cap);
        if (f == FUNC_APPEND || f == FUNC_INSERT) begin
            if (model_count >= eff) begin
                r.st = STAT_FULL;
            end else begin
                slot = (f == FUNC_APPEND || p > model_count) ? model_count : int'(p);
                for (int k = model_count; k > slot; k--)
                    model_words[k] = model_words[k-1];
                model_words[slot] = v;
                model_count++;
                r.pos = slot[5:0];
            end
        end else if (p >= model_count) begin
            r.st = STAT_RANGE;
        end else if (f == FUNC_ERASE) begin
            for (int k = int'(p); k + 1 < model_count; k++)
                model_words[k] = model_words[k+1];
            model_count--;
            r.pos = p;
        end else begin
            r.rd  = model_words[p];
            r.pos = p;
        end
        r.size = model_count[5:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        bit      busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                busy = 1'b1;
                n_res++;
                got = '{o_read_value, o_position_out, o_size_now, t_status'(o_status)};
                if (pending_results.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected result rd=%h pos=%0d size=%0d st=%0d",
                             $time, got.rd, got.pos, got.size, got.st);
                end else begin
                    want = pending_results.pop_front();
                    if (got.rd !== want.rd) begin
                        n_err++;
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.rd, got.rd);
                    end
                    if (got.pos !== want.pos) begin
                        n_err++;
                        $display("%0t: position_out expected %0d actual %0d",
                                 $time, want.pos, got.pos);
                    end
                    if (got.size !== want.size) begin
                        n_err++;
                        $display("%0t: size_now expected %0d actual %0d",
                                 $time, want.size, got.size);
                    end
                    if (got.st !== want.st) begin
                        n_err++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, got.st);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                busy = 1'b1;
                n_req++;
                want = apply_request(t_func'(i_func), i_position, i_value);
                if (want.st <= STAT_RANGE)
                    n_stat[want.st]++;
                pending_results.insert(pending_results.size(), cur_chk ? cur_exp : want);
            end
            if (i_cfg_we) begin
                busy = 1'b1;
                n_cfg++;
                model_cap = i_cfg_wdata;
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
        end
    end

    // receiver back-pressure: free runs, short stalls and the odd long one
    initial begin : stall_gen
        int  run;
        bit  stall;
        int  r;
        i_out_stall = 1'b0;
        stall = 1'b0;
        forever begin
            stall = ~stall;
            r = $urandom_range(0, 99);
            if (!stall)
                run = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            else
                run = (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            repeat (run) begin
                @(negedge i_clk);
                i_out_stall <= stall;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mode 0 grows the array, mode 1 mixes, mode 2 shrinks it
    function automatic t_func pick_func(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (r < 40) return FUNC_APPEND;
                if (r < 80) return FUNC_INSERT;
                if (r < 90) return FUNC_ERASE;
                return FUNC_READ;
            end
            1: begin
                return t_func'(r % 4);
            end
            default: begin
                if (r < 45) return FUNC_ERASE;
                if (r < 70) return FUNC_READ;
                if (r < 85) return FUNC_APPEND;
                return FUNC_INSERT;
            end
        endcase
    endfunction

    function automatic logic [5:0] pick_position(t_func f);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 6'($urandom_range(0, 63));
        if (r < 30) begin
            case ($urandom_range(0, 2))
                0:       return 6'd0;
                1:       return 6'(model_count);
                default: return 6'((model_count > 0) ? model_count - 1 : 0);
            endcase
        end
        if (f == FUNC_INSERT || f == FUNC_APPEND)
            return 6'($urandom_range(0, model_count));
        return 6'((model_count > 0) ? $urandom_range(0, model_count - 1) : 0);
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 80)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            2:       return 32'h7fffffff;
            default: return 32'h80000000;
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_request(t_func f, logic [5:0] p, logic [31:0] v,
                                bit chk, t_result exp, int gap);
        cur_chk    = chk;
        cur_exp    = exp;
        i_func     <= f;
        i_position <= p;
        i_value    <= v;
        i_in_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // capacity is only changed with nothing in flight
    task automatic set_capacity(logic [5:0] cap);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("tb_indexed_insert_erase_array: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_func   f;
        t_result none;
        int      mode;
        bit      calm;
        none        = '{32'h0, 6'd0, 6'd0, STAT_OK};
        cur_chk     = 1'b0;
        cur_exp     = none;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 6'd0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_APPEND;
        i_position  = 6'd0;
        i_value     = 32'sd0;
        for (int k = 0; k < DEPTH; k++)
            model_words[k] = 32'h0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].kind == ROW_CFG)
                set_capacity(dir_tab[k].cap);
            else
                send_request(dir_tab[k].f, dir_tab[k].p, dir_tab[k].v,
                             dir_tab[k].chk, dir_tab[k].exp, pick_gap());
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_capacity(6'(phase_cap[ph]));
            mode = ph % 3;
            calm = (ph % 4 == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                f = pick_func(mode);
                send_request(f, pick_position(f), pick_value(), 1'b0, none,
                             calm ? 0 : pick_gap());
            end
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d requests and %0d results over %0d capacity writes",
                 n_req, n_res, n_cfg);
        $display("  predicted status: %0d ok, %0d full, %0d out of range",
                 n_stat[0], n_stat[1], n_stat[2]);
        if (n_err == 0) begin
            $display("tb_indexed_insert_erase_array: PASS");
        end else begin
            $display("tb_indexed_insert_erase_array: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/iiea_pkg.sv
rtl/core/iiea_cell.sv
rtl/core/indexed_insert_erase_array.sv
verif/tb_indexed_insert_erase_array.sv
